### hw/rtl/dlsd_pkg.sv
// Shared constants and gain tables for the delay line stereo decoder.
package dlsd_pkg;

    localparam int NUM_LINES   = 8;
    localparam int SAMPLE_BITS = 24;
    localparam int IDX_W       = $clog2(NUM_LINES);
    localparam int MUL_W       = 33;
    localparam int PROD_W      = 2 * MUL_W;
    localparam int GAIN_W      = 26;

    localparam logic [1:0] MODE_TABLE  = 2'd0;
    localparam logic [1:0] MODE_LEGACY = 2'd1;
    localparam logic [1:0] MODE_LEGROT = 2'd2;
    localparam logic [1:0] MODE_MONO   = 2'd3;

    localparam logic [1:0] CFG_MODE  = 2'd0;
    localparam logic [1:0] CFG_DEPTH = 2'd1;

    localparam logic [16:0] DEPTH_ONE = 17'd65536;

    localparam logic signed [GAIN_W-1:0] G_A = 26'sd8285330;
    localparam logic signed [GAIN_W-1:0] G_B = 26'sd1312267;
    localparam logic signed [GAIN_W-1:0] G_H = 26'sd8388608;
    localparam logic signed [GAIN_W-1:0] G_C = 26'sd5931642;

    localparam logic [22:0] K_LEGACY = 23'd3690988;
    localparam logic [22:0] K_MONO   = 23'd4697620;

    localparam logic [30:0] C_SIX   = 31'd178956971;
    localparam logic [30:0] C_ONE20 = 31'd8947849;
    localparam logic [30:0] C_5040  = 31'd213044;
    localparam logic [30:0] C_TWO4  = 31'd44739243;
    localparam logic [30:0] C_720   = 31'd1491308;

    localparam logic signed [31:0] Q30_ONE = 32'sd1073741824;

    // Fixed equal-power table, one entry per line.
    function automatic logic signed [GAIN_W-1:0] f_tab(input logic [IDX_W-1:0] idx,
                                                       input logic left);
        logic signed [GAIN_W-1:0] g;
        unique case (idx)
            3'd0:    g = left ? G_A  : G_B;
            3'd1:    g = left ? G_H  : 26'sd0;
            3'd2:    g = left ? -G_B : -G_A;
            3'd3:    g = left ? -G_H : 26'sd0;
            3'd4:    g = left ? G_B  : G_A;
            3'd5:    g = left ? 26'sd0 : -G_H;
            3'd6:    g = left ? -G_A : -G_B;
            3'd7:    g = left ? 26'sd0 : G_H;
            default: g = 26'sd0;
        endcase
        return g;
    endfunction

    // Legacy sign matrix scaled by 1/sqrt8.
    function automatic logic signed [GAIN_W-1:0] f_legacy(input logic [IDX_W-1:0] idx,
                                                          input logic left);
        logic neg;
        neg = left ? idx[1] : (idx[0] ^ idx[1]);
        return neg ? -G_C : G_C;
    endfunction

    // Base gain ahead of rotation: signed legacy or table magnitude.
    function automatic logic signed [GAIN_W-1:0] f_base(input logic [IDX_W-1:0] idx,
                                                        input logic mono,
                                                        input logic left);
        logic signed [GAIN_W-1:0] t;
        t = f_tab(idx, left);
        if (mono) begin
            return (t < 0) ? -t : t;
        end
        return f_legacy(idx, left);
    endfunction

    // Polarity of a line in mono-safe mode.
    function automatic logic f_pol_neg(input logic [IDX_W-1:0] idx);
        logic signed [GAIN_W:0] s;
        s = (GAIN_W+1)'(f_tab(idx, 1'b1)) + (GAIN_W+1)'(f_tab(idx, 1'b0));
        return s < 0;
    endfunction

endpackage

### hw/rtl/delay_line_stereo_decoder.sv
// Top level: sequencer around one shared multiplier, accumulators and output register.
//
//  channel | direction | handshake               | payload
//  in      | sink      | i_in_valid / o_in_stall  | i_line_index, i_line_sample,
//          |           |                         | i_field_position
//  out     | source    | o_out_valid / i_out_stall| o_left_out, o_right_out
//  cfg     | sink      | i_cfg_we                | i_cfg_index, i_cfg_data
//
// Every step drives the multiplier in ST_MUL and writes the registered product back in ST_WB.
// Rotated modes with nonzero depth take 17 steps; other modes take two steps.
// Input stalls whenever the sequencer is out of ST_IDLE.
// A line 7 transaction waits in ST_DONE while the output register is full and i_out_stall is high.
// Reset is synchronous, active low; it clears control state, config registers, accumulators and output valid.
module delay_line_stereo_decoder (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    input  logic                                      i_in_valid,
    output logic                                      o_in_stall,
    input  logic [dlsd_pkg::IDX_W-1:0]                i_line_index,
    input  logic signed [dlsd_pkg::SAMPLE_BITS-1:0]   i_line_sample,
    input  logic signed [15:0]                        i_field_position,
    output logic                                      o_out_valid,
    input  logic                                      i_out_stall,
    output logic signed [dlsd_pkg::SAMPLE_BITS-1:0]   o_left_out,
    output logic signed [dlsd_pkg::SAMPLE_BITS-1:0]   o_right_out,
    input  logic                                      i_cfg_we,
    input  logic [1:0]                                i_cfg_index,
    input  logic [16:0]                               i_cfg_data
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_MUL  = 2'd1;
    localparam logic [1:0] ST_WB   = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    localparam logic [4:0] OP_DP    = 5'd0;
    localparam logic [4:0] OP_ANG   = 5'd1;
    localparam logic [4:0] OP_SQ    = 5'd2;
    localparam logic [4:0] OP_P4    = 5'd3;
    localparam logic [4:0] OP_P6    = 5'd4;
    localparam logic [4:0] OP_T6    = 5'd5;
    localparam logic [4:0] OP_T120  = 5'd6;
    localparam logic [4:0] OP_T5040 = 5'd7;
    localparam logic [4:0] OP_T24   = 5'd8;
    localparam logic [4:0] OP_T720  = 5'd9;
    localparam logic [4:0] OP_SIN   = 5'd10;
    localparam logic [4:0] OP_CB    = 5'd11;
    localparam logic [4:0] OP_SR    = 5'd12;
    localparam logic [4:0] OP_SB    = 5'd13;
    localparam logic [4:0] OP_CR    = 5'd14;
    localparam logic [4:0] OP_GL    = 5'd15;
    localparam logic [4:0] OP_GR    = 5'd16;

    localparam int PW = dlsd_pkg::PROD_W;
    localparam int GW = dlsd_pkg::GAIN_W;
    localparam int SB = dlsd_pkg::SAMPLE_BITS;
    localparam logic [dlsd_pkg::IDX_W-1:0] LAST_LINE = dlsd_pkg::IDX_W'(dlsd_pkg::NUM_LINES - 1);

    // Round half away from zero.
    function automatic logic signed [PW-1:0] f_rnd(input logic signed [PW-1:0] v, input int s);
        logic signed [PW-1:0] h;
        logic signed [PW-1:0] m;
        h = PW'(1) <<< (s - 1);
        m = -v;
        if (v >= 0) begin
            return (v + h) >>> s;
        end
        return -((m + h) >>> s);
    endfunction

    function automatic logic signed [31:0] f_sat_add(input logic signed [31:0] acc,
                                                     input logic signed [PW-1:0] c);
        logic signed [33:0] s;
        s = 34'(acc) + 34'(c);
        if (s > 34'sd2147483647) begin
            return 32'sh7FFFFFFF;
        end
        if (s < -34'sd2147483648) begin
            return 32'sh80000000;
        end
        return 32'(s);
    endfunction

    function automatic logic signed [SB-1:0] f_sat_out(input logic signed [31:0] v);
        logic signed [31:0] hi;
        logic signed [31:0] lo;
        hi = (32'sd1 <<< (SB - 1)) - 32'sd1;
        lo = -hi - 32'sd1;
        if (v > hi) begin
            return SB'(hi);
        end
        if (v < lo) begin
            return SB'(lo);
        end
        return SB'(v);
    endfunction

    logic [1:0]                    r_mode;
    logic [16:0]                   r_depth_cfg;
    logic [1:0]                    r_state;
    logic [4:0]                    r_op;
    logic [dlsd_pkg::IDX_W-1:0]    r_idx;
    logic signed [SB-1:0]          r_sample;
    logic                          r_neg;
    logic [15:0]                   r_pmag;
    logic [31:0]                   r_dp;
    logic [30:0]                   r_mag;
    logic [30:0]                   r_sq;
    logic [30:0]                   r_p4;
    logic [30:0]                   r_p6;
    logic signed [31:0]            r_sin;
    logic signed [31:0]            r_cos;
    logic signed [PW-1:0]          r_tmp;
    logic signed [GW-1:0]          r_gl;
    logic signed [GW-1:0]          r_gr;
    logic signed [31:0]            r_acc_l;
    logic signed [31:0]            r_acc_r;
    logic                          r_out_valid;
    logic signed [SB-1:0]          r_out_l;
    logic signed [SB-1:0]          r_out_r;

    logic [16:0]                   w_depth;
    logic                          w_rot;
    logic                          w_mono;
    logic                          w_in_acc;
    logic                          w_load;
    logic signed [dlsd_pkg::MUL_W-1:0] w_a;
    logic signed [dlsd_pkg::MUL_W-1:0] w_b;
    logic signed [PW-1:0]          w_p;
    logic signed [PW-1:0]          w_rnd30;
    logic [30:0]                   w_uq;
    logic signed [GW-1:0]          w_bl;
    logic signed [GW-1:0]          w_br;
    logic signed [GW-1:0]          w_mr;
    logic signed [GW-1:0]          w_ml_fix;
    logic signed [GW-1:0]          w_mr_fix;

    assign w_depth  = (r_depth_cfg > dlsd_pkg::DEPTH_ONE) ? dlsd_pkg::DEPTH_ONE : r_depth_cfg;
    assign w_rot    = ((r_mode == dlsd_pkg::MODE_LEGROT) || (r_mode == dlsd_pkg::MODE_MONO))
                      && (w_depth != 17'd0);
    assign w_mono   = (r_mode == dlsd_pkg::MODE_MONO);
    assign w_in_acc = i_in_valid && !o_in_stall;
    assign w_load   = (r_state == ST_DONE) && (r_idx == LAST_LINE)
                      && (!r_out_valid || !i_out_stall);

    assign w_bl = dlsd_pkg::f_base(r_idx, w_mono, 1'b1);
    assign w_br = dlsd_pkg::f_base(r_idx, w_mono, 1'b0);

    assign w_rnd30 = w_p + (PW'(1) <<< 29);
    assign w_uq    = w_rnd30[60:30];
    assign w_mr    = GW'(f_rnd(r_tmp + w_p, 30));

    // Mono-safe escape: pin the pair when a magnitude collapses.
    always_comb begin
        if (r_gl <= 0) begin
            w_ml_fix = '0;
            w_mr_fix = dlsd_pkg::G_H;
        end else if (w_mr <= 0) begin
            w_ml_fix = dlsd_pkg::G_H;
            w_mr_fix = '0;
        end else begin
            w_ml_fix = r_gl;
            w_mr_fix = w_mr;
        end
    end

    always_comb begin
        w_a = '0;
        w_b = '0;
        unique case (r_op)
            OP_DP:    begin w_a = $signed({16'd0, w_depth}); w_b = $signed({17'd0, r_pmag}); end
            OP_ANG:   begin
                w_a = $signed({10'd0, w_mono ? dlsd_pkg::K_MONO : dlsd_pkg::K_LEGACY});
                w_b = $signed({1'b0, r_dp});
            end
            OP_SQ:    begin w_a = $signed({2'd0, r_mag}); w_b = $signed({2'd0, r_mag}); end
            OP_P4:    begin w_a = $signed({2'd0, r_sq});  w_b = $signed({2'd0, r_sq});  end
            OP_P6:    begin w_a = $signed({2'd0, r_p4});  w_b = $signed({2'd0, r_sq});  end
            OP_T6:    begin w_a = $signed({2'd0, r_sq});  w_b = $signed({2'd0, dlsd_pkg::C_SIX}); end
            OP_T120:  begin w_a = $signed({2'd0, r_p4});  w_b = $signed({2'd0, dlsd_pkg::C_ONE20}); end
            OP_T5040: begin w_a = $signed({2'd0, r_p6});  w_b = $signed({2'd0, dlsd_pkg::C_5040}); end
            OP_T24:   begin w_a = $signed({2'd0, r_p4});  w_b = $signed({2'd0, dlsd_pkg::C_TWO4}); end
            OP_T720:  begin w_a = $signed({2'd0, r_p6});  w_b = $signed({2'd0, dlsd_pkg::C_720}); end
            OP_SIN:   begin w_a = $signed({2'd0, r_mag}); w_b = 33'(r_sin); end
            OP_CB:    begin w_a = 33'(r_cos); w_b = 33'(w_bl); end
            OP_SR:    begin w_a = 33'(r_sin); w_b = 33'(w_br); end
            OP_SB:    begin w_a = 33'(r_sin); w_b = 33'(w_bl); end
            OP_CR:    begin w_a = 33'(r_cos); w_b = 33'(w_br); end
            OP_GL:    begin w_a = 33'(r_gl);  w_b = 33'(r_sample); end
            OP_GR:    begin w_a = 33'(r_gr);  w_b = 33'(r_sample); end
            default:  begin w_a = '0; w_b = '0; end
        endcase
    end

    dlsd_mul u_mul (
        .i_clk (i_clk),
        .i_a   (w_a),
        .i_b   (w_b),
        .o_p   (w_p)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= dlsd_pkg::MODE_TABLE;
            r_depth_cfg <= '0;
        end else if (i_cfg_we) begin
            if (i_cfg_index == dlsd_pkg::CFG_MODE) begin
                r_mode <= i_cfg_data[1:0];
            end else if (i_cfg_index == dlsd_pkg::CFG_DEPTH) begin
                r_depth_cfg <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_op        <= OP_DP;
            r_acc_l     <= '0;
            r_acc_r     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (w_in_acc) begin
                        r_idx    <= i_line_index;
                        r_sample <= i_line_sample;
                        r_neg    <= i_field_position[15];
                        r_pmag   <= i_field_position[15] ? 16'(-i_field_position)
                                                         : 16'(i_field_position);
                        r_state  <= ST_MUL;
                        if (w_rot) begin
                            r_op <= OP_DP;
                        end else begin
                            r_op <= OP_GL;
                            if ((r_mode == dlsd_pkg::MODE_TABLE) || w_mono) begin
                                r_gl <= dlsd_pkg::f_tab(i_line_index, 1'b1);
                                r_gr <= dlsd_pkg::f_tab(i_line_index, 1'b0);
                            end else begin
                                r_gl <= dlsd_pkg::f_legacy(i_line_index, 1'b1);
                                r_gr <= dlsd_pkg::f_legacy(i_line_index, 1'b0);
                            end
                        end
                    end
                end
                ST_MUL: begin
                    r_state <= ST_WB;
                end
                ST_WB: begin
                    r_state <= (r_op == OP_GR) ? ST_DONE : ST_MUL;
                    r_op    <= (r_op == OP_GR) ? r_op : r_op + 5'd1;
                    unique case (r_op)
                        OP_DP:    r_dp  <= w_p[31:0];
                        OP_ANG:   r_mag <= 31'((w_p + (PW'(1) <<< 24)) >>> 25);
                        OP_SQ:    r_sq  <= w_uq;
                        OP_P4:    r_p4  <= w_uq;
                        OP_P6:    r_p6  <= w_uq;
                        OP_T6:    r_sin <= dlsd_pkg::Q30_ONE - $signed({1'b0, w_uq});
                        OP_T120:  r_sin <= r_sin + $signed({1'b0, w_uq});
                        OP_T5040: r_sin <= r_sin - $signed({1'b0, w_uq});
                        OP_T24:   r_cos <= dlsd_pkg::Q30_ONE - $signed({2'b0, r_sq[30:1]})
                                           + $signed({1'b0, w_uq});
                        OP_T720:  r_cos <= r_cos - $signed({1'b0, w_uq});
                        OP_SIN:   r_sin <= r_neg ? -$signed({1'b0, w_uq}) : $signed({1'b0, w_uq});
                        OP_CB:    r_tmp <= w_p;
                        OP_SR:    r_gl  <= GW'(f_rnd(r_tmp - w_p, 30));
                        OP_SB:    r_tmp <= w_p;
                        OP_CR: begin
                            if (w_mono) begin
                                r_gl <= dlsd_pkg::f_pol_neg(r_idx) ? -w_ml_fix : w_ml_fix;
                                r_gr <= dlsd_pkg::f_pol_neg(r_idx) ? -w_mr_fix : w_mr_fix;
                            end else begin
                                r_gr <= w_mr;
                            end
                        end
                        OP_GL:    r_acc_l <= f_sat_add(r_acc_l, f_rnd(w_p, 24));
                        OP_GR:    r_acc_r <= f_sat_add(r_acc_r, f_rnd(w_p, 24));
                        default:  r_tmp <= r_tmp;
                    endcase
                end
                ST_DONE: begin
                    // hold a finished frame until the output register frees up
                    if (r_idx != LAST_LINE) begin
                        r_state <= ST_IDLE;
                    end else if (w_load) begin
                        r_out_l <= f_sat_out(r_acc_l);
                        r_out_r <= f_sat_out(r_acc_r);
                        r_acc_l <= '0;
                        r_acc_r <= '0;
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_left_out  = r_out_l;
    assign o_right_out = r_out_r;

    a_stall_after_acc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> o_in_stall)
        else $error("input taken while previous transaction in flight");

    a_acc_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load |=> (r_acc_l == 32'sd0) && (r_acc_r == 32'sd0))
        else $error("accumulators not cleared after frame");

    a_op_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_op <= OP_GR)
        else $error("step counter out of range");

    a_load_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load |-> (r_state == ST_DONE) && (r_idx == LAST_LINE))
        else $error("frame emitted for a line other than the last");

endmodule

### hw/rtl/dlsd_mul.sv
// Shared signed multiplier with registered product.
module dlsd_mul (
    input  logic                                 i_clk,
    input  logic signed [dlsd_pkg::MUL_W-1:0]    i_a,
    input  logic signed [dlsd_pkg::MUL_W-1:0]    i_b,
    output logic signed [dlsd_pkg::PROD_W-1:0]   o_p
);

    logic signed [dlsd_pkg::PROD_W-1:0] r_p;

    always_ff @(posedge i_clk) begin
        r_p <= i_a * i_b;
    end

    assign o_p = r_p;

endmodule

### tb/sv/dlsd_checker.sv
// Checker for the delay line stereo decoder: predicts stereo frames and compares them.
`timescale 1ns / 100ps

module dlsd_checker (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_in_valid,
    input  logic                                    i_in_stall,
    input  logic [dlsd_pkg::IDX_W-1:0]              i_line_index,
    input  logic signed [dlsd_pkg::SAMPLE_BITS-1:0] i_line_sample,
    input  logic signed [15:0]                      i_field_position,
    input  logic                                    i_out_valid,
    input  logic                                    i_out_stall,
    input  logic signed [dlsd_pkg::SAMPLE_BITS-1:0] i_left_out,
    input  logic signed [dlsd_pkg::SAMPLE_BITS-1:0] i_right_out,
    input  logic                                    i_cfg_we,
    input  logic [1:0]                              i_cfg_index,
    input  logic [16:0]                             i_cfg_data,
    output int                                      o_errors,
    output int                                      o_frames_pending
);
    import dlsd_pkg::*;

    typedef struct {
        logic signed [SAMPLE_BITS-1:0] left;
        logic signed [SAMPLE_BITS-1:0] right;
    } frame_t;

    typedef struct {
        longint sine;
        longint cosine;
    } trig_t;

    localparam longint Q30 = 64'sd1073741824;

    frame_t      frame_q[$];
    logic [1:0]  cur_mode;
    logic [16:0] cur_depth;
    longint      acc_left;
    longint      acc_right;

    longint tab_l[8];
    longint tab_r[8];
    longint sgn_l[8];
    longint sgn_r[8];

    initial begin
        tab_l = '{G_A, G_H, -G_B, -G_H, G_B, 0, -G_A, 0};
        tab_r = '{G_B, 0, -G_A, 0, G_A, -G_H, -G_B, G_H};
        sgn_l = '{1, 1, -1, -1, 1, 1, -1, -1};
        sgn_r = '{1, -1, -1, 1, 1, -1, -1, 1};
    end

    assign o_frames_pending = frame_q.size();

    // Round half away from zero.
    function automatic longint round_away(longint v, int s);
        longint half;
        half = 64'sd1 <<< (s - 1);
        if (v >= 0) return (v + half) >>> s;
        return -(((-v) + half) >>> s);
    endfunction

    function automatic longint unsigned mul_q30(longint unsigned a, longint unsigned b);
        return (a * b + (64'd1 << 29)) >> 30;
    endfunction

    function automatic trig_t rotation(longint unsigned k, longint unsigned depth,
                                       longint pos);
        trig_t r;
        longint unsigned pmag, ang, sq, p4, p6;
        longint sin_in, smag;
        pmag = (pos < 0) ? longint'(-pos) : longint'(pos);
        ang = (k * depth * pmag + (64'd1 << 24)) >> 25;
        sq = mul_q30(ang, ang);
        p4 = mul_q30(sq, sq);
        p6 = mul_q30(p4, sq);
        sin_in = Q30 - longint'(mul_q30(sq, C_SIX)) + longint'(mul_q30(p4, C_ONE20))
                 - longint'(mul_q30(p6, C_5040));
        r.cosine = Q30 - longint'(sq >> 1) + longint'(mul_q30(p4, C_TWO4))
                   - longint'(mul_q30(p6, C_720));
        smag = longint'(mul_q30(ang, longint'(sin_in)));
        r.sine = (pos < 0) ? -smag : smag;
        return r;
    endfunction

    function automatic longint sat32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic logic signed [SAMPLE_BITS-1:0] sat_sample(longint v);
        longint hi;
        hi = (64'sd1 <<< (SAMPLE_BITS - 1)) - 1;
        if (v > hi) v = hi;
        if (v < -hi - 1) v = -hi - 1;
        return v[SAMPLE_BITS-1:0];
    endfunction

    // Add one line's weighted sample; queue a frame on the last line.
    task automatic mix_line(int idx, longint smp, longint pos);
        longint unsigned depth;
        longint gl, gr, al, ar, pol, ml, mr;
        trig_t t;
        frame_t f;
        depth = (cur_depth > DEPTH_ONE) ? DEPTH_ONE : cur_depth;
        if (cur_mode == MODE_TABLE || (cur_mode == MODE_MONO && depth == 0)) begin
            gl = tab_l[idx];
            gr = tab_r[idx];
        end else if (cur_mode == MODE_LEGACY || (cur_mode == MODE_LEGROT && depth == 0)) begin
            gl = sgn_l[idx] * G_C;
            gr = sgn_r[idx] * G_C;
        end else if (cur_mode == MODE_LEGROT) begin
            t = rotation(K_LEGACY, depth, pos);
            gl = round_away(t.cosine * sgn_l[idx] * G_C - t.sine * sgn_r[idx] * G_C, 30);
            gr = round_away(t.sine * sgn_l[idx] * G_C + t.cosine * sgn_r[idx] * G_C, 30);
        end else begin
            t = rotation(K_MONO, depth, pos);
            al = (tab_l[idx] < 0) ? -tab_l[idx] : tab_l[idx];
            ar = (tab_r[idx] < 0) ? -tab_r[idx] : tab_r[idx];
            pol = (tab_l[idx] + tab_r[idx] >= 0) ? 1 : -1;
            ml = round_away(t.cosine * al - t.sine * ar, 30);
            mr = round_away(t.sine * al + t.cosine * ar, 30);
            // Pin the pair when a magnitude collapses.
            if (ml <= 0) begin
                ml = 0;
                mr = G_H;
            end else if (mr <= 0) begin
                ml = G_H;
                mr = 0;
            end
            gl = pol * ml;
            gr = pol * mr;
        end
        acc_left = sat32(acc_left + round_away(gl * smp, 24));
        acc_right = sat32(acc_right + round_away(gr * smp, 24));
        if (idx == NUM_LINES - 1) begin
            f.left = sat_sample(acc_left);
            f.right = sat_sample(acc_right);
            frame_q.push_back(f);
            acc_left = 0;
            acc_right = 0;
        end
    endtask

    task automatic report(string msg);
        $display("tb: mismatch at %0t: %s", $realtime, msg);
        o_errors++;
    endtask

    always @(posedge i_clk) begin
        frame_t f;
        if (!i_rst_n) begin
            cur_mode <= MODE_TABLE;
            cur_depth <= '0;
            acc_left = 0;
            acc_right = 0;
            frame_q.delete();
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_MODE) cur_mode <= i_cfg_data[1:0];
                else if (i_cfg_index == CFG_DEPTH) cur_depth <= i_cfg_data;
            end
            if (i_in_valid && !i_in_stall)
                mix_line(i_line_index, i_line_sample, i_field_position);
            if (i_out_valid && !i_out_stall) begin
                if (frame_q.size() == 0) begin
                    report("frame with no expectation");
                end else begin
                    f = frame_q.pop_front();
                    if (i_left_out !== f.left)
                        report($sformatf("left %0d, expected %0d", i_left_out, f.left));
                    if (i_right_out !== f.right)
                        report($sformatf("right %0d, expected %0d", i_right_out, f.right));
                end
            end
        end
    end

endmodule

### tb/sv/testbench.sv
// Testbench top: clock, reset, stimulus, output back-pressure and verdict.
`timescale 1ns / 100ps

module testbench;
    import dlsd_pkg::*;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          i_in_valid = 1'b0;
    logic                          o_in_stall;
    logic [IDX_W-1:0]              i_line_index = '0;
    logic signed [SAMPLE_BITS-1:0] i_line_sample = '0;
    logic signed [15:0]            i_field_position = '0;
    logic                          o_out_valid;
    logic                          i_out_stall = 1'b1;
    logic signed [SAMPLE_BITS-1:0] o_left_out;
    logic signed [SAMPLE_BITS-1:0] o_right_out;
    logic                          i_cfg_we = 1'b0;
    logic [1:0]                    i_cfg_index = CFG_MODE;
    logic [16:0]                   i_cfg_data = '0;

    int errors;
    int frames_pending;
    int idle_max = 16;
    bit hold_request = 0;
    int next_line = 0;

    always #4 i_clk = ~i_clk;

    delay_line_stereo_decoder i_dut (.*);

    dlsd_checker i_checker (
        .i_clk, .i_rst_n, .i_in_valid, .i_in_stall(o_in_stall), .i_line_index,
        .i_line_sample, .i_field_position, .i_out_valid(o_out_valid), .i_out_stall,
        .i_left_out(o_left_out), .i_right_out(o_right_out), .i_cfg_we, .i_cfg_index,
        .i_cfg_data, .o_errors(errors), .o_frames_pending(frames_pending)
    );

    // Receiver: random stall per frame, one long hold on request.
    initial begin
        int n;
        @(posedge i_clk iff i_rst_n);
        forever begin
            if (hold_request) begin
                hold_request = 0;
                i_out_stall <= 1'b1;
                repeat (600) @(posedge i_clk);
            end else begin
                n = $urandom_range(idle_max, 0);
                if (n > 0) begin
                    i_out_stall <= 1'b1;
                    repeat (n) @(posedge i_clk);
                end
            end
            i_out_stall <= 1'b0;
            do @(posedge i_clk); while (!o_out_valid && !hold_request);
        end
    end

    // Valid stays high after a transaction; lower it only when a gap follows.
    task automatic send_line(int idx, logic signed [SAMPLE_BITS-1:0] smp,
                             logic signed [15:0] pos);
        int gap;
        gap = $urandom_range(idle_max, 0);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_line_index <= IDX_W'(idx);
        i_line_sample <= smp;
        i_field_position <= pos;
        i_in_valid <= 1'b1;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [16:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Drain outstanding frames, let an unfinished line settle, then reconfigure.
    task automatic set_decode(logic [1:0] mode, logic [16:0] depth);
        if (i_in_valid) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        wait (frames_pending == 0);
        repeat (40) @(posedge i_clk);
        write_reg(CFG_MODE, mode);
        write_reg(CFG_DEPTH, depth);
    endtask

    function automatic logic signed [SAMPLE_BITS-1:0] pick_sample();
        case ($urandom_range(9, 0))
            0: return {1'b1, {(SAMPLE_BITS-1){1'b0}}};
            1: return {1'b0, {(SAMPLE_BITS-1){1'b1}}};
            2: return SAMPLE_BITS'($urandom_range(8, 0) - 4);
            default: return SAMPLE_BITS'($urandom);
        endcase
    endfunction

    function automatic logic signed [15:0] pick_position();
        case ($urandom_range(9, 0))
            0: return 16'sh8000;
            1: return 16'sh7fff;
            2: return 16'sd0;
            default: return 16'($urandom);
        endcase
    endfunction

    // Mostly ordered frames; some repeated, skipped or shuffled lines.
    task automatic send_random(int count);
        int idx;
        repeat (count) begin
            if ($urandom_range(9, 0) == 0) begin
                idx = $urandom_range(7, 0);
            end else begin
                idx = next_line;
                next_line = (next_line + 1) % NUM_LINES;
            end
            send_line(idx, pick_sample(), pick_position());
        end
    endtask

    task automatic send_extreme_frame(logic signed [15:0] pos);
        for (int k = 0; k < NUM_LINES; k++)
            send_line(k, k[0] ? 24'sh7fffff : 24'sh800000, k[1] ? -pos : pos);
    endtask

    initial begin
        logic [1:0] modes[12];
        logic [16:0] depths[12];
        modes = '{MODE_TABLE, MODE_LEGACY, MODE_LEGROT, MODE_MONO,
                  MODE_LEGROT, MODE_MONO, MODE_LEGROT, MODE_MONO,
                  MODE_LEGROT, MODE_MONO, MODE_TABLE, MODE_LEGACY};
        depths = '{17'd0, 17'd0, 17'd0, 17'd0, 17'd65536, 17'd65536,
                   17'd131071, 17'd1, 17'd0, 17'd0, 17'd99999, 17'd65535};
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: saturating frames in each decode, plus depth extremes.
        send_extreme_frame(16'sh7fff);
        set_decode(MODE_LEGACY, 17'd0);
        send_extreme_frame(16'sh8000);
        set_decode(MODE_LEGROT, 17'd65536);
        send_extreme_frame(16'sh8000);
        set_decode(MODE_MONO, 17'd131071);
        send_extreme_frame(16'sh7fff);

        for (int p = 0; p < 12; p++) begin
            if (p >= 8 && depths[p] == 0) depths[p] = 17'($urandom_range(131071, 1));
            set_decode(modes[p], depths[p]);
            if (p == 5) begin
                idle_max = 0;
                hold_request = 1;
            end else if (p == 9) begin
                idle_max = 0;
            end else begin
                idle_max = 16;
            end
            send_random(115);
        end

        i_in_valid <= 1'b0;
        idle_max = 16;
        wait (frames_pending == 0);
        repeat (60) @(posedge i_clk);
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    initial begin
        #20ms;
        $display("tb: failure");
        $finish;
    end

endmodule
